### hdl/rational_arithmetic_reduce_unit_assert.svh
// assertion macros for the rational arithmetic reduce unit checker
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef RATIONAL_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rar_pkg.sv
// shared types and constants of the rational arithmetic reduce unit
// no dependencies
package rar_pkg;

  localparam int PART_W = 16;       // width of one input numerator or denominator
  localparam int PROD_W = 2 * PART_W + 2;  // signed raw numerator width
  localparam int MAG_W  = 2 * PART_W;  // magnitude and denominator width
  localparam int RNUM_W = MAG_W + 1;   // result numerator width
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int SH_W   = $clog2(MAG_W) + 1;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_PREP, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL0, OP_MUL1, OP_MUL2, OP_PREP, OP_GCD, OP_DIVN, OP_DIVD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic skip;
    logic gcd_eq;
    logic cnt_last;
  } stat_t;

endpackage

### hdl/rar_if.sv
// item channels of the rational arithmetic reduce unit
// depends on rar_pkg
interface rar_in_if import rar_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [PART_W-1:0] a_num;
  logic [PART_W-1:0]        a_den;
  logic signed [PART_W-1:0] b_num;
  logic [PART_W-1:0]        b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if import rar_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RNUM_W-1:0] res_num;
  logic [MAG_W-1:0]         res_den;
  logic                     status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

### hdl/rar_seq.sv
// sequencer: steps one item through multiply, gcd and divide phases
// depends on rar_pkg
module rar_seq import rar_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL0;
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_PREP;
      ST_PREP: state_nxt = stat.skip ? ST_FIN : ST_GCD;
      ST_GCD:  if (stat.gcd_eq) state_nxt = ST_DIVN;
      ST_DIVN: if (stat.cnt_last) state_nxt = ST_DIVD;
      ST_DIVD: if (stat.cnt_last) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.op       = OP_NONE;
    ctrl.out_load = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctrl.op = OP_LOAD;
      end
      ST_MUL0: ctrl.op = OP_MUL0;
      ST_MUL1: ctrl.op = OP_MUL1;
      ST_MUL2: ctrl.op = OP_MUL2;
      ST_PREP: ctrl.op = OP_PREP;
      ST_GCD:  ctrl.op = OP_GCD;
      ST_DIVN: ctrl.op = OP_DIVN;
      ST_DIVD: ctrl.op = OP_DIVD;
      ST_FIN:  ctrl.out_load = !out_valid_r || out_ready;
      default: ctrl.op = OP_NONE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/rar_dp.sv
// datapath: shared multiplier, shared subtractor, gcd and divider registers
// depends on rar_pkg
module rar_dp import rar_pkg::*; (
  input  logic                     clk,
  input  ctrl_t                    ctrl,
  input  logic [1:0]               action,
  input  logic signed [PART_W-1:0] a_num,
  input  logic [PART_W-1:0]        a_den,
  input  logic signed [PART_W-1:0] b_num,
  input  logic [PART_W-1:0]        b_den,
  output stat_t                    stat,
  output logic signed [RNUM_W-1:0] res_num,
  output logic [MAG_W-1:0]         res_den,
  output logic                     status
);

  logic [1:0]               act_r;
  logic signed [PART_W-1:0] an_r, bn_r;
  logic [PART_W-1:0]        ad_r, bd_r;
  logic signed [PROD_W-1:0] p1_r, num_r;
  logic [MAG_W-1:0]         den_r, x_r, y_r, mag_r, q_r;
  logic [MAG_W-1:0]         rem_r;
  logic [SH_W-1:0]          k_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     neg_r;
  logic signed [RNUM_W-1:0] res_num_r;
  logic [MAG_W-1:0]         res_den_r;
  logic                     status_r;

  logic signed [PART_W:0]   ma, mb;
  logic signed [PROD_W-1:0] prod;
  logic [PART_W-1:0]        bn_abs;
  logic [MAG_W:0]           sub_a, sub_b, rem_sh;
  logic [MAG_W+1:0]         diff;
  logic                     borrow;
  logic [MAG_W-1:0]         q_nxt, mag;
  logic [MAG_W-1:0]         rem_nxt;
  logic signed [PROD_W-1:0] num_neg;
  logic [PROD_W-1:0]        q_ext;
  logic                     div_zero;

  assign bn_abs = bn_r[PART_W-1] ? PART_W'(-bn_r) : bn_r;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      OP_MUL0: begin
        ma = {1'b0, ad_r};
        mb = (act_r == ACT_DIV) ? {1'b0, bn_abs} : {1'b0, bd_r};
      end
      OP_MUL1: begin
        ma = {an_r[PART_W-1], an_r};
        mb = (act_r == ACT_MUL) ? {bn_r[PART_W-1], bn_r} : {1'b0, bd_r};
      end
      default: begin
        ma = {1'b0, ad_r};
        mb = {bn_r[PART_W-1], bn_r};
      end
    endcase
  end

  // operands sign-extended to the full product width
  assign prod = PROD_W'(ma) * PROD_W'(mb);

  // shared subtractor: gcd compare or divider trial subtract
  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  always_comb begin
    if (ctrl.op == OP_GCD) begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, y_r};
    end else begin
      sub_a = rem_sh;
      sub_b = {1'b0, x_r};
    end
  end
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[MAG_W+1];

  // divider step, the remainder always stays below the divisor
  assign rem_nxt = borrow ? rem_sh[MAG_W-1:0] : diff[MAG_W-1:0];
  assign q_nxt   = {q_r[MAG_W-2:0], !borrow};
  assign q_ext   = {2'b00, q_nxt};

  // sign handling of the raw numerator
  assign num_neg  = PROD_W'(0) - num_r;
  assign mag      = num_r[PROD_W-1] ? num_neg[MAG_W-1:0] : num_r[MAG_W-1:0];
  assign div_zero = (act_r == ACT_DIV) && (bn_r == '0);

  assign stat.skip     = div_zero || (num_r == '0) || (den_r == '0);
  assign stat.gcd_eq   = (x_r == y_r);
  assign stat.cnt_last = (cnt_r == CNT_W'(MAG_W - 1));

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        act_r <= action;
        an_r  <= a_num;
        ad_r  <= a_den;
        bn_r  <= b_num;
        bd_r  <= b_den;
      end
      OP_MUL0: den_r <= prod[MAG_W-1:0];
      OP_MUL1: p1_r <= prod;
      OP_MUL2: begin
        case (act_r)
          ACT_ADD: num_r <= p1_r + prod;
          ACT_SUB: num_r <= p1_r - prod;
          ACT_MUL: num_r <= p1_r;
          default: num_r <= bn_r[PART_W-1] ? PROD_W'(0) - p1_r : p1_r;
        endcase
      end
      OP_PREP: begin
        x_r   <= mag;
        y_r   <= den_r;
        mag_r <= mag;
        neg_r <= num_r[PROD_W-1];
        k_r   <= '0;
      end
      OP_GCD: begin
        // binary gcd: strip common twos, strip single twos, subtract or swap odd pairs
        if (x_r == y_r) begin
          q_r   <= mag_r >> k_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + SH_W'(1);
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (!borrow) begin
          x_r <= diff[MAG_W-1:0];
        end else begin
          x_r <= y_r;
          y_r <= x_r;
        end
      end
      OP_DIVN: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (stat.cnt_last) begin
          num_r <= neg_r ? PROD_W'(0) - q_ext : q_ext;
          q_r   <= den_r >> k_r;
          rem_r <= '0;
        end else begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
        end
      end
      OP_DIVD: begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (stat.cnt_last) den_r <= q_nxt;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res_num_r <= num_r[RNUM_W-1:0];
      res_den_r <= den_r;
      status_r  <= div_zero;
    end
  end

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign status  = status_r;

endmodule

### hdl/rational_arithmetic_reduce_unit.sv
// top level of the rational arithmetic reduce unit
// depends on rar_pkg, rar_if, rar_seq and rar_dp
//
//   channel   dir   handshake      payload
//   in_if     in    valid/ready    action, a_num, a_den, b_num, b_den
//   out_if    out   valid/ready    res_num, res_den, status
//
// one item at a time: the item is accepted, multiplied in MUL0, MUL1 and
// MUL2 on the shared 17x17 multiplier and set up in PREP, then a binary gcd
// runs on the shared subtractor (a shift, subtract or swap per step) and two
// restoring divisions run on the same subtractor; zero numerator, zero
// denominator or divide by zero skip gcd and division. a finished result
// sits in the output register, so the next item is accepted while it waits.
// reset is synchronous, active low
module rational_arithmetic_reduce_unit import rar_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  rar_in_if.sink   in_if,
  rar_out_if.source out_if
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  rar_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // datapath
  rar_dp u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .action  (in_if.action),
    .a_num   (in_if.a_num),
    .a_den   (in_if.a_den),
    .b_num   (in_if.b_num),
    .b_den   (in_if.b_den),
    .stat    (stat),
    .res_num (out_if.res_num),
    .res_den (out_if.res_den),
    .status  (out_if.status)
  );

endmodule

### hdl/rar_chk.sv
// port-level checker for the rational arithmetic reduce unit, with its bind
// depends on rar_pkg and rational_arithmetic_reduce_unit_assert.svh
`include "rational_arithmetic_reduce_unit_assert.svh"

module rar_chk import rar_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [RNUM_W-1:0] res_num,
  input logic [MAG_W-1:0]  res_den,
  input logic              status
);

  // a stalled result holds
  `RAR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_num) && $stable(res_den) && $stable(status), "stalled result item changed")

  // divide by zero always reports a zero denominator
  `RAR_ASSERT_NOW(a_status_den, out_valid && status, res_den == '0, "status set with nonzero denominator")

  // busy after an item is taken
  `RAR_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "item accepted while busy")

  // no result can appear the cycle after an item starts
  `RAR_ASSERT_NXT(a_no_instant, in_valid && in_ready && !out_valid, !out_valid, "result appeared too early")

endmodule

bind rational_arithmetic_reduce_unit rar_chk u_rar_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .res_num   (out_if.res_num),
  .res_den   (out_if.res_den),
  .status    (out_if.status)
);
